>>> src/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
// no dependencies
`timescale 1ns / 1ps
package sem_pkg;
  localparam int MaxWidth = 1024;
  localparam int AddrW = $clog2(MaxWidth);
  localparam int PixW = 24;
  localparam logic [10:0] MaxWidth11 = 11'(MaxWidth);
  localparam logic [0:0] CfgWidth = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef logic [7:0] chan_t;
  typedef logic [PixW-1:0] pix_t;
endpackage

>>> src/sem_ram.sv
// generic single port ram, registered read
// no dependencies
`timescale 1ns / 1ps
module sem_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> src/sem_mag.sv
// sobel gradient and rounded magnitude for one channel
// depends on sem_pkg
`timescale 1ns / 1ps
module sem_mag
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        start,
  input  chan_t       p [9],
  input  logic [8:0]  msk,
  output logic        done,
  output chan_t       mag
);
  logic signed [11:0] gx, gy;
  logic [20:0] s_r, s_nxt;
  logic [8:0] n_r, n_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [8:0] trial;
  logic [17:0] sq;
  logic signed [9:0] v [9];

  // masked taps and kernels
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      v[i] = msk[i] ? {2'b00, p[i]} : 10'sd0;
    end
    gx = 12'(v[2]) - 12'(v[0]) + 12'(v[8]) - 12'(v[6]) + 12'(v[5] <<< 1) - 12'(v[3] <<< 1);
    gy = 12'(v[6]) - 12'(v[0]) + 12'(v[8]) - 12'(v[2]) + 12'(v[7] <<< 1) - 12'(v[1] <<< 1);
  end

  // bitwise square root, one bit per cycle, then round
  always_comb begin
    trial = n_r | (9'd1 << cnt_r);
    sq = 18'(trial) * 18'(trial);
    s_nxt = s_r;
    n_nxt = n_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done = 1'b0;
    if (start) begin
      s_nxt = 21'(gx * gx) + 21'(gy * gy);
      n_nxt = '0;
      cnt_nxt = 4'd7;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 4'd8) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end else begin
        if (21'(sq) <= s_r) begin
          n_nxt = trial;
        end
        cnt_nxt = (cnt_r == 4'd0) ? 4'd8 : cnt_r - 4'd1;
      end
    end
  end

  always_comb begin
    if (s_r > 21'd65280) begin
      mag = 8'd255;
    end else if (s_r > 21'(n_r) * 21'(n_r) + 21'(n_r)) begin
      mag = (n_r >= 9'd255) ? 8'd255 : 8'(n_r + 9'd1);
    end else begin
      mag = 8'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    n_r <= n_nxt;
    cnt_r <= cnt_nxt;
    busy_r <= busy_nxt;
  end
endmodule

>>> src/sobel_edge_magnitude_rgb_unit.sv
// top level: streaming 3x3 sobel edge magnitude on rgb pixels
// throughput: a new pixel is taken only once every result of the previous pixel has been
// emitted and accepted; the bit serial square root in each channel unit dominates
// reset: synchronous active low, clears counters, window and control; line stores stay undefined
// depends on sem_pkg, sem_ram, sem_mag
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_unit
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_edge,
  output logic [7:0]  out_green_edge,
  output logic [7:0]  out_blue_edge,
  output logic [15:0] out_row,
  output logic [9:0]  out_col,
  output logic        out_last_of_run,
  output logic        out_frame_end,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  state_t st_r, st_nxt;
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [9:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  pix_t win_r [3][3];
  pix_t pix_r;
  pix_t top_d, mid_d;
  logic [3:0] pend_r, pend_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic run_r, run_nxt;
  logic start;
  logic [2:0] dn;
  chan_t mg [3];
  logic [10:0] w_eff;
  logic [15:0] h_eff;
  logic last_col, last_row;
  logic [15:0] rc;
  logic [9:0] cc;
  logic [8:0] msk;
  chan_t tap [3][9];
  logic ovalid_r;
  logic rd_we;
  logic [AddrW-1:0] addr;

  assign w_eff = (width_r == 11'd0) ? 11'd1 : ((width_r > MaxWidth11) ? MaxWidth11 : width_r);
  assign h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
  assign last_col = (11'(col_r) + 11'd1) >= w_eff;
  assign last_row = (17'(row_r) + 17'd1) >= 17'(h_eff);
  assign addr = AddrW'(col_r);
  assign rd_we = (st_r == ST_READ);

  sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_two (
    .clk(clk), .we(rd_we), .addr(addr), .wdata(mid_d), .rdata(top_d)
  );
  sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_one (
    .clk(clk), .we(rd_we), .addr(addr), .wdata(pix_r), .rdata(mid_d)
  );

  // centre of the current result
  always_comb begin
    rc = row_r;
    cc = col_r;
    if (sel_r == 2'd0 || sel_r == 2'd1) begin
      rc = row_r - 16'd1;
    end
    if (sel_r == 2'd0 || sel_r == 2'd2) begin
      cc = col_r - 10'd1;
    end
  end

  // neighbor mask: in frame and inside window
  always_comb begin
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        logic signed [17:0] rr, cw, wi, wj;
        rr = 18'($signed({2'b00, rc})) + 18'(dr) - 18'sd1;
        cw = 18'($signed({8'd0, cc})) + 18'(dc) - 18'sd1;
        wi = rr - 18'($signed({2'b00, row_r})) + 18'sd2;
        wj = cw - 18'($signed({8'd0, col_r})) + 18'sd2;
        msk[dr*3+dc] = !(rr < 0) && !(cw < 0) && (rr < 18'($signed({2'b00, h_eff})))
                       && (cw < 18'($signed({7'd0, w_eff}))) && !(wi < 0) && !(wi > 2)
                       && !(wj < 0) && !(wj > 2);
        for (int ch = 0; ch < 3; ch++) begin
          tap[ch][dr*3+dc] = win_r[2'(wi)][2'(wj)][16-8*ch +: 8];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    sem_mag u_mag (
      .clk(clk), .start(start), .p(tap[ch]), .msk(msk), .done(dn[ch]), .mag(mg[ch])
    );
  end

  assign in_ready = (st_r == ST_IDLE);
  assign out_valid = ovalid_r;

  // sequencer for read, update and per result emission
  always_comb begin
    st_nxt = st_r;
    col_nxt = col_r;
    row_nxt = row_r;
    pend_nxt = pend_r;
    sel_nxt = sel_r;
    run_nxt = run_r;
    start = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        st_nxt = ST_EMIT;
        pend_nxt = {last_row && last_col, last_row && (col_r != 10'd0),
                    last_col && (row_r != 16'd0), (row_r != 16'd0) && (col_r != 10'd0)};
        sel_nxt = 2'd0;
        run_nxt = 1'b0;
      end
      ST_EMIT: begin
        if (!run_r && !ovalid_r) begin
          if (pend_r == 4'd0) begin
            st_nxt = ST_IDLE;
            if (last_col) begin
              col_nxt = '0;
              row_nxt = last_row ? 16'd0 : row_r + 16'd1;
            end else begin
              col_nxt = col_r + 10'd1;
            end
          end else if (pend_r[sel_r]) begin
            start = 1'b1;
            run_nxt = 1'b1;
          end else begin
            sel_nxt = sel_r + 2'd1;
          end
        end else if (run_r && dn[0]) begin
          run_nxt = 1'b0;
          pend_nxt[sel_r] = 1'b0;
          sel_nxt = sel_r + 2'd1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      width_r <= 11'd640;
      height_r <= 16'd480;
      col_r <= '0;
      row_r <= '0;
      pend_r <= '0;
      sel_r <= '0;
      run_r <= 1'b0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      st_r <= st_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      pend_r <= pend_nxt;
      sel_r <= sel_nxt;
      run_r <= run_nxt;
      if (cfg_we) begin
        if (cfg_index == CfgWidth) begin
          width_r <= cfg_data[10:0];
        end else begin
          height_r <= cfg_data;
        end
      end
      if (st_r == ST_IDLE && in_valid) begin
        pix_r <= {in_red_in, in_green_in, in_blue_in};
      end
      if (st_r == ST_READ) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= top_d;
        win_r[1][2] <= mid_d;
        win_r[2][2] <= pix_r;
      end
      // output register
      if (run_r && dn[0]) begin
        ovalid_r <= 1'b1;
        out_red_edge <= mg[0];
        out_green_edge <= mg[1];
        out_blue_edge <= mg[2];
        out_row <= rc;
        out_col <= cc;
        out_last_of_run <= ((pend_r >> (sel_r + 2'd1)) == 4'd0) || (sel_r == 2'd3);
        out_frame_end <= (sel_r == 2'd3);
      end else if (ovalid_r && out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end
endmodule

>>> tb/tb_top.sv
// testbench for the streaming sobel edge magnitude block: predicts every result
// from its own copy of line stores, window and counters; depends on sem_pkg and the rtl
`timescale 1ns / 1ps
module tb_top;
  import sem_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] row;
    logic [9:0]  col;
    logic        last_of_run;
    logic        frame_end;
  } edge_res_t;

  localparam int CycleLimit = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_red_in;
  logic [7:0]  in_green_in;
  logic [7:0]  in_blue_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red_edge;
  logic [7:0]  out_green_edge;
  logic [7:0]  out_blue_edge;
  logic [15:0] out_row;
  logic [9:0]  out_col;
  logic        out_last_of_run;
  logic        out_frame_end;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  sobel_edge_magnitude_rgb_unit dut (.*);

  // predictor state
  logic [10:0] pred_width;
  logic [15:0] pred_height;
  pix_t        store_above [MaxWidth];
  pix_t        store_two_above [MaxWidth];
  pix_t        win [3][3];
  int unsigned col_cnt;
  int unsigned row_cnt;

  edge_res_t   expected_edges[$];
  int          fail_count;
  int          cycle_count;
  int          recv_idle_pct;
  int          send_idle_pct;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // integer rounded square root, saturated at 255
  function automatic logic [7:0] grad_mag(input int gx, input int gy);
    int unsigned s;
    int unsigned n;
    s = gx * gx + gy * gy;
    if (s > 65280) return 8'd255;
    n = 0;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return (n > 255) ? 8'd255 : 8'(n);
  endfunction

  function automatic edge_res_t centre_result(input int rc, input int cc, input int r,
                                              input int c, input int w, input int h);
    edge_res_t res;
    int gx[3];
    int gy[3];
    int kx;
    int ky;
    int i;
    int j;
    int v;
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch] = 0;
      gy[ch] = 0;
    end
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        i = rc + dr - (r - 2);
        j = cc + dc - (c - 2);
        if (rc + dr < 0 || cc + dc < 0 || rc + dr >= h || cc + dc >= w) continue;
        if (i < 0 || i > 2 || j < 0 || j > 2) continue;
        kx = dc * ((dr == 0) ? 2 : 1);
        ky = dr * ((dc == 0) ? 2 : 1);
        for (int ch = 0; ch < 3; ch++) begin
          v = win[i][j][16-8*ch +: 8];
          gx[ch] += kx * v;
          gy[ch] += ky * v;
        end
      end
    end
    res.red = grad_mag(gx[0], gy[0]);
    res.green = grad_mag(gx[1], gy[1]);
    res.blue = grad_mag(gx[2], gy[2]);
    res.row = 16'(rc);
    res.col = 10'(cc);
    res.last_of_run = 1'b0;
    res.frame_end = 1'b0;
    return res;
  endfunction

  // advance the predictor by one pixel and queue its results
  task automatic predict_pixel(input pix_t pix);
    edge_res_t batch[$];
    edge_res_t res;
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit last_col;
    bit last_row;
    pix_t top;
    pix_t mid;
    w = (pred_width == 0) ? 1 : pred_width;
    h = (pred_height == 0) ? 1 : pred_height;
    if (w > MaxWidth) w = MaxWidth;
    c = col_cnt;
    r = row_cnt;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    top = '0;
    mid = '0;
    if (c < MaxWidth) begin
      top = store_two_above[c];
      mid = store_above[c];
      store_two_above[c] = mid;
      store_above[c] = pix;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (r >= 1 && c >= 1) batch.push_back(centre_result(r - 1, c - 1, r, c, w, h));
    if (last_col && r >= 1) batch.push_back(centre_result(r - 1, c, r, c, w, h));
    if (last_row && c >= 1) batch.push_back(centre_result(r, c - 1, r, c, w, h));
    if (last_row && last_col) begin
      res = centre_result(r, c, r, c, w, h);
      res.frame_end = 1'b1;
      batch.push_back(res);
    end
    if (batch.size() > 0) batch[batch.size()-1].last_of_run = 1'b1;
    foreach (batch[k]) expected_edges.push_back(batch[k]);
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // send one pixel; valid held until the transfer, dropped by idling or drain
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= red;
    in_green_in <= green;
    in_blue_in <= blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel({red, green, blue});
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // wait until all results are in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_edges.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgWidth) pred_width = value[10:0];
    else pred_height = value;
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
    drain();
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
  endtask

  task automatic send_frame(input int n);
    repeat (n) send_random_pixel();
  endtask

  // result checker
  always @(posedge clk) begin
    edge_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_edges.pop_front();
        if (out_red_edge !== want.red) report_mismatch("red_edge");
        if (out_green_edge !== want.green) report_mismatch("green_edge");
        if (out_blue_edge !== want.blue) report_mismatch("blue_edge");
        if (out_row !== want.row) report_mismatch("out_row");
        if (out_col !== want.col) report_mismatch("out_col");
        if (out_last_of_run !== want.last_of_run) report_mismatch("last_of_run");
        if (out_frame_end !== want.frame_end) report_mismatch("frame_end");
      end
    end
  end

  // receiver readiness, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // extremes of every field on a tiny 3x3 frame, then a single pixel frame
  task automatic test_directed();
    set_frame(16'd3, 16'd3);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'haa, 8'h55, 8'haa);
    // single pixel frame
    set_frame(16'd1, 16'd1);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h01, 8'h7f);
  endtask

  // zero registers act as one, width above the store on a short stretch of a row
  task automatic test_register_corners();
    set_frame(16'd0, 16'd0);
    send_frame(3);
    set_frame(16'd1, 16'd4);
    send_frame(4);
    set_frame(16'd5, 16'd1);
    send_frame(5);
    set_frame(16'd2047, 16'd2);
    send_frame(16);
    set_frame(16'd1024, 16'd1);
    send_frame(16);
  endtask

  // tall narrow frame exercises large row numbers
  task automatic test_tall_frame();
    set_frame(16'd1, 16'hffff);
    send_frame(40);
  endtask

  // registers changed mid frame: counts wrap at the new size
  task automatic test_midframe_change();
    set_frame(16'd6, 16'd6);
    send_frame(9);
    set_frame(16'd3, 16'd4);
    send_frame(14);
  endtask

  // receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    set_frame(16'd4, 16'd3);
    hold_cycles = 300;
    send_frame(12);
    // sender pauses until everything has come
    drain();
    send_frame(12);
  endtask

  // random small frames, with a stretch of no idling
  task automatic test_random_frames();
    int w;
    int h;
    for (int f = 0; f < 12; f++) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      if (f == 4) begin
        recv_idle_pct = 0;
        send_idle_pct = 0;
      end else if (f == 7) begin
        recv_idle_pct = 36;
        send_idle_pct = 36;
      end
      set_frame(16'(w), 16'(h));
      send_frame(w * h);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    hold_cycles = 0;
    recv_idle_pct = 36;
    send_idle_pct = 36;
    pred_width = 11'd640;
    pred_height = 16'd480;
    col_cnt = 0;
    row_cnt = 0;
    for (int i = 0; i < MaxWidth; i++) begin
      store_above[i] = '0;
      store_two_above[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_corners();
    test_tall_frame();
    test_midframe_change();
    test_backpressure();
    test_random_frames();
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
